/* rtl/lpcd_pkg.sv */
// Package for the length-prefixed command deframer.
// Holds the register indexes, status and kind codes and the shared structs.
// No dependencies.
package lpcd_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_STREAM_CODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STREAM_HEADER    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BINARY_FIRST_MAX = 2'd2;

  localparam logic [7:0] STREAM_CODE_RST      = 8'd50;
  localparam logic [7:0] STREAM_HEADER_RST    = 8'd7;
  localparam logic [7:0] BINARY_FIRST_MAX_RST = 8'd64;

  localparam logic [15:0] MIN_STREAM_TOTAL = 16'd3;

  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_LOSS = 1'b1;

  localparam logic [1:0] ST_FRAME = 2'd0;
  localparam logic [1:0] ST_DROP  = 2'd1;
  localparam logic [1:0] ST_ABORT = 2'd2;

  localparam logic KIND_BIN    = 1'b0;
  localparam logic KIND_STREAM = 1'b1;

  typedef struct packed {
    logic [7:0] stream_code;
    logic [7:0] stream_header_len;
    logic [7:0] binary_first_max;
  } cfg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       frame_kind;
    logic       first_of_frame;
    logic       last_of_frame;
  } result_t;

  typedef struct packed {
    logic has_result;
    logic busy;
  } parse_stat_t;

endpackage

/* rtl/lpcd_if.sv */
// Channel interfaces of the length-prefixed command deframer.
// Depends on nothing but the field widths of the deframer.
interface lpcd_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink (input valid, input func, input rx_byte, output ready);
endinterface

interface lpcd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       frame_kind;
  logic       first_of_frame;
  logic       last_of_frame;

  modport source (output valid, output out_byte, output status, output frame_kind,
                  output first_of_frame, output last_of_frame, input ready);
  modport sink (input valid, input out_byte, input status, input frame_kind,
                input first_of_frame, input last_of_frame, output ready);
endinterface

interface lpcd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/lpcd_cfg_regs.sv */
// Configuration registers of the length-prefixed command deframer.
// Depends on lpcd_pkg and the lpcd_cfg_if interface.
module lpcd_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  lpcd_cfg_if.sink      cfg_chan,
  output lpcd_pkg::cfg_t cfg
);

  lpcd_pkg::cfg_t cfg_r;

  assign cfg_chan.ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stream_code       <= lpcd_pkg::STREAM_CODE_RST;
      cfg_r.stream_header_len <= lpcd_pkg::STREAM_HEADER_RST;
      cfg_r.binary_first_max  <= lpcd_pkg::BINARY_FIRST_MAX_RST;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        lpcd_pkg::REG_STREAM_CODE:      cfg_r.stream_code       <= cfg_chan.data;
        lpcd_pkg::REG_STREAM_HEADER:    cfg_r.stream_header_len <= cfg_chan.data;
        lpcd_pkg::REG_BINARY_FIRST_MAX: cfg_r.binary_first_max  <= cfg_chan.data;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/lpcd_parser.sv */
// Frame parser of the length-prefixed command deframer: frame state and tagging.
// Depends on lpcd_pkg.
module lpcd_parser (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lpcd_pkg::cfg_t         cfg,
  input  logic                   step,
  input  logic                   func,
  input  logic [7:0]             rx_byte,
  output lpcd_pkg::result_t      res,
  output lpcd_pkg::parse_stat_t  stat
);

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_LEN_LO      = 3'd1,
    PH_LEN_HI      = 3'd2,
    PH_STREAM_BODY = 3'd3,
    PH_BIN_BODY    = 3'd4
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] left_r, left_nxt;
  logic [7:0]  len_lo_r, len_lo_nxt;
  logic        kind_r, kind_nxt;
  logic        active;
  logic        has_res;
  logic [15:0] total;
  logic [15:0] left_dec;

  assign total    = {8'd0, cfg.stream_header_len} + {rx_byte, len_lo_r};
  assign left_dec = (left_r != 16'd0) ? left_r - 16'd1 : 16'd0;

  always_comb begin
    phase_nxt  = phase_r;
    left_nxt   = left_r;
    len_lo_nxt = len_lo_r;
    kind_nxt   = kind_r;
    has_res    = 1'b1;
    res        = '{out_byte: rx_byte, status: lpcd_pkg::ST_FRAME,
                   frame_kind: kind_r, first_of_frame: 1'b0, last_of_frame: 1'b0};
    unique case (phase_r)
      PH_LEN_LO, PH_LEN_HI, PH_STREAM_BODY, PH_BIN_BODY: active = 1'b1;
      default: active = 1'b0;
    endcase

    if (func == lpcd_pkg::FUNC_LOSS) begin
      phase_nxt = PH_IDLE;
      if (active) begin
        left_nxt     = 16'd0;
        res.out_byte = 8'd0;
        res.status   = lpcd_pkg::ST_ABORT;
      end else begin
        has_res = 1'b0;
      end
    end else begin
      unique case (phase_r)
        PH_LEN_LO: begin
          len_lo_nxt     = rx_byte;
          phase_nxt      = PH_LEN_HI;
          res.frame_kind = lpcd_pkg::KIND_STREAM;
        end
        PH_LEN_HI: begin
          res.frame_kind = lpcd_pkg::KIND_STREAM;
          if (total <= lpcd_pkg::MIN_STREAM_TOTAL) begin
            left_nxt          = 16'd0;
            phase_nxt         = PH_IDLE;
            res.last_of_frame = 1'b1;
          end else begin
            left_nxt  = total - lpcd_pkg::MIN_STREAM_TOTAL;
            phase_nxt = PH_STREAM_BODY;
          end
        end
        PH_STREAM_BODY, PH_BIN_BODY: begin
          res.frame_kind = (phase_r == PH_STREAM_BODY) ? lpcd_pkg::KIND_STREAM
                                                       : lpcd_pkg::KIND_BIN;
          left_nxt = left_dec;
          if (left_dec == 16'd0) begin
            phase_nxt         = PH_IDLE;
            res.last_of_frame = 1'b1;
          end
        end
        default: begin
          res.first_of_frame = 1'b1;
          if (rx_byte == cfg.stream_code) begin
            kind_nxt       = lpcd_pkg::KIND_STREAM;
            phase_nxt      = PH_LEN_LO;
            res.frame_kind = lpcd_pkg::KIND_STREAM;
          end else if (rx_byte <= cfg.binary_first_max) begin
            kind_nxt       = lpcd_pkg::KIND_BIN;
            res.frame_kind = lpcd_pkg::KIND_BIN;
            left_nxt       = {8'd0, rx_byte};
            if (rx_byte == 8'd0) begin
              phase_nxt         = PH_IDLE;
              res.last_of_frame = 1'b1;
            end else begin
              phase_nxt = PH_BIN_BODY;
            end
          end else begin
            phase_nxt          = PH_IDLE;
            res.status         = lpcd_pkg::ST_DROP;
            res.frame_kind     = lpcd_pkg::KIND_BIN;
            res.first_of_frame = 1'b0;
          end
        end
      endcase
    end
  end

  assign stat.has_result = has_res;
  assign stat.busy       = active;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      left_r   <= 16'd0;
      len_lo_r <= 8'd0;
      kind_r   <= lpcd_pkg::KIND_BIN;
    end else if (step) begin
      phase_r  <= phase_nxt;
      left_r   <= left_nxt;
      len_lo_r <= len_lo_nxt;
      kind_r   <= kind_nxt;
    end
  end

endmodule

/* rtl/length_prefixed_command_deframer.sv */
// Top level of the length-prefixed command deframer.
// Depends on lpcd_pkg, the lpcd interfaces, lpcd_cfg_regs and lpcd_parser.
//
// Received bytes enter on in_chan (func 0 with rx_byte, or func 1 for a lost
// connection) and leave registered on out_chan, each tagged with its status,
// frame kind and first/last markers. An unknown leading byte is passed on as
// dropped; a lost connection in the middle of a frame gives one abort item,
// and while idle it gives no item at all.
// An accepted item is held in an input register; when the parser steps, it tags
// the item and writes the result register, which offers the result on out_chan.
// One item is taken in every cycle while out_chan does not stall, limited
// otherwise only by the single parse step through the frame state.
// When the receiver stalls, the result register holds its item and the input
// register holds one more; in_chan.ready then drops until the result is taken.
// cfg_chan is always ready; registers 0 to 2 are the stream code, the stream
// header length and the largest binary leading byte; the user writes them while
// idle, which the block does not enforce. Reset (rst_n low, synchronous) empties
// both registers, returns the parser to idle and restores the defaults 50, 7, 64.
module length_prefixed_command_deframer (
  input logic         clk,
  input logic         rst_n,
  lpcd_in_if.sink     in_chan,
  lpcd_out_if.source  out_chan,
  lpcd_cfg_if.sink    cfg_chan
);

  lpcd_pkg::cfg_t        cfg;
  lpcd_pkg::result_t     res;
  lpcd_pkg::parse_stat_t stat;
  lpcd_pkg::result_t     out_r;

  logic       stg_vld_r;
  logic       stg_func_r;
  logic [7:0] stg_byte_r;
  logic       out_vld_r;
  logic       advance;
  logic       in_take;

  assign advance       = stg_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready = !stg_vld_r || advance;
  assign in_take       = in_chan.valid && in_chan.ready;

  lpcd_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  lpcd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .step    (advance),
    .func    (stg_func_r),
    .rx_byte (stg_byte_r),
    .res     (res),
    .stat    (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_chan.ready) begin
        stg_vld_r <= in_chan.valid;
      end
      if (advance) begin
        out_vld_r <= stat.has_result;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stg_func_r <= in_chan.func;
      stg_byte_r <= in_chan.rx_byte;
    end
    if (advance && stat.has_result) begin
      out_r <= res;
    end
  end

  assign out_chan.valid          = out_vld_r;
  assign out_chan.out_byte       = out_r.out_byte;
  assign out_chan.status         = out_r.status;
  assign out_chan.frame_kind     = out_r.frame_kind;
  assign out_chan.first_of_frame = out_r.first_of_frame;
  assign out_chan.last_of_frame  = out_r.last_of_frame;

  a_take_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> stg_vld_r)
    else $error("accepted item did not reach the input register");

  a_stall_holds_parser: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_chan.ready) |-> !advance)
    else $error("parser stepped while the result register was stalled");

  a_loss_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && stg_func_r == lpcd_pkg::FUNC_LOSS) |=> !stat.busy)
    else $error("parser not idle after a connection loss");

  a_idle_loss_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && stg_func_r == lpcd_pkg::FUNC_LOSS && !stat.busy) |=> !out_vld_r)
    else $error("connection loss while idle produced an item");

endmodule
